[rtl/mmcc_pkg.sv]
// Shared types and constants for the mesh mapping communication cost block.
// Holds the request/response word layouts, mode codes and CSR indexes.
// No dependencies.
package mmcc_pkg;

   localparam int COST_W     = 48;
   localparam int CORE_W     = 8;
   localparam int POS_W      = 8;
   localparam int VOL_FIELD_W = 24;
   localparam int MESH_DIM_W = 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_PLACE = 2'd1;
   localparam logic [1:0] MODE_EDGE  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_MESH_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MESH_HEIGHT = 2'd1;

   typedef struct packed {
      logic [1:0]             mode;
      logic [CORE_W-1:0]      core_id;
      logic [POS_W-1:0]       tile_position;
      logic [CORE_W-1:0]      peer_core;
      logic [VOL_FIELD_W-1:0] traffic_volume;
      logic                   last_edge;
   } req_word_type;

   typedef struct packed {
      logic [COST_W-1:0] total_cost;
      logic              missing_core;
      logic              saturated;
   } rsp_word_type;

   // One lane of the restoring divider: partial remainder and the
   // dividend shifting out while quotient bits shift in.
   typedef struct packed {
      logic [MESH_DIM_W-1:0] rem;
      logic [POS_W-1:0]      quo;
   } div_lane_type;

endpackage

[rtl/mesh_mapping_comm_cost_top.sv]
// Mesh mapping communication cost: scores a core-to-tile placement on a 2D mesh.
// Top level with the tile table memory, divider lanes and cost accumulator.
// Depends on mmcc_pkg.
//
//   Channel | Direction | Handshake            | Word
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | req_data (mode, cores, volume)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_data (cost, flags)
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// Sequence: clear, place and unused-mode words are handled in the idle state. An
// edge word steps through table read, the divider at two quotient bits per
// cycle, multiply, accumulate, then the output load with last_edge. An edge
// naming a missing core or off-mesh tile stops after the table read.
// Reset: synchronous; placed bits live in flops and clear at once, so there is
// no clearing pass. Tile entries are undefined until a core is placed.
// Stalls: one output register; a new word is taken while a result waits, and
// only a further result waits in the output state until rsp_stall drops.
module mesh_mapping_comm_cost_top import mmcc_pkg::*; #(
   parameter int MAX_CORES   = 256,
   parameter int VOLUME_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [MESH_DIM_W-1:0]  csr_wdata
);

   // Core ids are 8 bits wide, so at most 256 entries are ever addressed.
   localparam int TBL_DEPTH = (MAX_CORES < (1 << CORE_W)) ? MAX_CORES : (1 << CORE_W);
   localparam int IDX_W     = $clog2(TBL_DEPTH);
   localparam int VOL_W     = (VOLUME_BITS < VOL_FIELD_W) ? VOLUME_BITS : VOL_FIELD_W;
   localparam int HOPS_W    = POS_W + 1;
   localparam int PROD_W    = VOL_W + HOPS_W;
   localparam int TILES_W   = 2 * MESH_DIM_W;
   localparam int DIV_STEPS = 2;
   localparam int DIV_CYC   = POS_W / DIV_STEPS;
   localparam int DCNT_W    = $clog2(DIV_CYC);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_CYC - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_ACC  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // Restoring division, DIV_STEPS quotient bits per call.
   function automatic div_lane_type div_step(div_lane_type lane,
                                             logic [MESH_DIM_W-1:0] divisor);
      div_lane_type          cur;
      logic [MESH_DIM_W:0]   trial;
      cur = lane;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {cur.rem, cur.quo[POS_W-1]};
         if (trial >= {1'b0, divisor}) begin
            cur.rem = MESH_DIM_W'(trial - {1'b0, divisor});
            cur.quo = {cur.quo[POS_W-2:0], 1'b1};
         end else begin
            cur.rem = trial[MESH_DIM_W-1:0];
            cur.quo = {cur.quo[POS_W-2:0], 1'b0};
         end
      end
      return cur;
   endfunction

   // Control state
   logic [2:0]            state_ff, state_in;
   logic [DCNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [TBL_DEPTH-1:0]  placed_ff, placed_in;
   logic [COST_W-1:0]     cost_ff, cost_in;
   logic                  missing_seen_ff, missing_seen_in;
   logic                  saturation_seen_ff, saturation_seen_in;
   logic [MESH_DIM_W-1:0] mesh_width_ff, mesh_width_in;
   logic [MESH_DIM_W-1:0] mesh_height_ff, mesh_height_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload state
   div_lane_type          src_lane_ff, src_lane_in;
   div_lane_type          dst_lane_ff, dst_lane_in;
   logic [VOL_W-1:0]      vol_ff, vol_in;
   logic                  last_ff, last_in;
   logic                  src_ok_ff, src_ok_in;
   logic                  dst_ok_ff, dst_ok_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   // Tile table
   logic [POS_W-1:0]      tile_mem [TBL_DEPTH];
   logic [POS_W-1:0]      rd_src_ff, rd_dst_ff;

   logic                  req_accept;
   logic                  rsp_free;
   logic [IDX_W-1:0]      src_idx, dst_idx;
   logic                  src_in_tbl, dst_in_tbl;
   logic                  mem_we, mem_re;
   logic [TILES_W-1:0]    tiles;
   logic                  src_in_mesh, dst_in_mesh;
   logic [POS_W-1:0]      quo_diff;
   logic [MESH_DIM_W-1:0] rem_diff;
   logic [HOPS_W-1:0]     hops;
   logic [COST_W:0]       sum_wide;
   logic [COST_W-1:0]     cost_acc;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign src_idx    = req_data.core_id[IDX_W-1:0];
   assign dst_idx    = req_data.peer_core[IDX_W-1:0];
   assign src_in_tbl = 32'(req_data.core_id) < 32'(MAX_CORES);
   assign dst_in_tbl = 32'(req_data.peer_core) < 32'(MAX_CORES);

   assign mem_we = req_accept && (req_data.mode == MODE_PLACE) && src_in_tbl;
   assign mem_re = req_accept && (req_data.mode == MODE_EDGE);

   // Mesh size is taken at edge time, so check range against live config.
   assign tiles       = TILES_W'(mesh_width_ff) * TILES_W'(mesh_height_ff);
   assign src_in_mesh = TILES_W'(rd_src_ff) < tiles;
   assign dst_in_mesh = TILES_W'(rd_dst_ff) < tiles;

   // Manhattan distance from row (quotient) and column (remainder).
   assign quo_diff = (src_lane_ff.quo > dst_lane_ff.quo) ?
                     POS_W'(src_lane_ff.quo - dst_lane_ff.quo) :
                     POS_W'(dst_lane_ff.quo - src_lane_ff.quo);
   assign rem_diff = (src_lane_ff.rem > dst_lane_ff.rem) ?
                     MESH_DIM_W'(src_lane_ff.rem - dst_lane_ff.rem) :
                     MESH_DIM_W'(dst_lane_ff.rem - src_lane_ff.rem);
   assign hops     = HOPS_W'(quo_diff) + HOPS_W'(rem_diff);

   // Saturating accumulate: clamp once the sum reaches the top code.
   assign sum_wide = {1'b0, cost_ff} + (COST_W + 1)'(prod_ff);
   assign cost_acc = (sum_wide >= {1'b0, COST_MAX}) ? COST_MAX : sum_wide[COST_W-1:0];

   always_comb begin
      state_in           = state_ff;
      div_cnt_in         = div_cnt_ff;
      placed_in          = placed_ff;
      cost_in            = cost_ff;
      missing_seen_in    = missing_seen_ff;
      saturation_seen_in = saturation_seen_ff;
      mesh_width_in      = mesh_width_ff;
      mesh_height_in     = mesh_height_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      src_lane_in        = src_lane_ff;
      dst_lane_in        = dst_lane_ff;
      vol_in             = vol_ff;
      last_in            = last_ff;
      src_ok_in          = src_ok_ff;
      dst_ok_in          = dst_ok_ff;
      prod_in            = prod_ff;
      rsp_data_in        = rsp_data_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MESH_WIDTH:  mesh_width_in  = csr_wdata;
            CSR_MESH_HEIGHT: mesh_height_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_data.mode)
                  MODE_CLEAR: begin
                     placed_in          = '0;
                     cost_in            = '0;
                     missing_seen_in    = 1'b0;
                     saturation_seen_in = 1'b0;
                  end
                  MODE_PLACE: begin
                     if (src_in_tbl) begin
                        placed_in[src_idx] = 1'b1;
                     end
                  end
                  MODE_EDGE: begin
                     // Latch placed bits now; tile data arrives next cycle.
                     src_ok_in = src_in_tbl && placed_ff[src_idx];
                     dst_ok_in = dst_in_tbl && placed_ff[dst_idx];
                     vol_in    = req_data.traffic_volume[VOL_W-1:0];
                     last_in   = req_data.last_edge;
                     state_in  = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            if (src_ok_ff && dst_ok_ff && src_in_mesh && dst_in_mesh) begin
               src_lane_in = '{rem: '0, quo: rd_src_ff};
               dst_lane_in = '{rem: '0, quo: rd_dst_ff};
               div_cnt_in  = '0;
               state_in    = S_DIV;
            end else begin
               missing_seen_in = 1'b1;
               state_in        = last_ff ? S_OUT : S_IDLE;
            end
         end
         S_DIV: begin
            src_lane_in = div_step(src_lane_ff, mesh_width_ff);
            dst_lane_in = div_step(dst_lane_ff, mesh_width_ff);
            div_cnt_in  = DCNT_W'(div_cnt_ff + 1'b1);
            if (div_cnt_ff == DCNT_LAST) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(vol_ff) * PROD_W'(hops);
            state_in = S_ACC;
         end
         S_ACC: begin
            cost_in = cost_acc;
            if (cost_acc == COST_MAX) begin
               saturation_seen_in = 1'b1;
            end
            state_in = last_ff ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            // Hold until the output register frees up.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{total_cost:   cost_ff,
                                missing_core: missing_seen_ff,
                                saturated:    saturation_seen_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         div_cnt_ff         <= '0;
         placed_ff          <= '0;
         cost_ff            <= '0;
         missing_seen_ff    <= 1'b0;
         saturation_seen_ff <= 1'b0;
         mesh_width_ff      <= MESH_DIM_W'(4);
         mesh_height_ff     <= MESH_DIM_W'(4);
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         div_cnt_ff         <= div_cnt_in;
         placed_ff          <= placed_in;
         cost_ff            <= cost_in;
         missing_seen_ff    <= missing_seen_in;
         saturation_seen_ff <= saturation_seen_in;
         mesh_width_ff      <= mesh_width_in;
         mesh_height_ff     <= mesh_height_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_lane_ff <= src_lane_in;
      dst_lane_ff <= dst_lane_in;
      vol_ff      <= vol_in;
      last_ff     <= last_in;
      src_ok_ff   <= src_ok_in;
      dst_ok_ff   <= dst_ok_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Tile table: one write port for placements, two registered read ports
   // for the edge's source and destination.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem[src_idx] <= req_data.tile_position;
      end
      if (mem_re) begin
         rd_src_ff <= tile_mem[src_idx];
         rd_dst_ff <= tile_mem[dst_idx];
      end
   end

   // A result is loaded only from the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result loaded outside the output state");

   // The saturation flag implies the sum is pinned at its top code.
   a_sat_pinned: assert property (@(posedge clock) disable iff (reset)
      saturation_seen_ff |-> cost_ff == COST_MAX)
      else $error("saturation flag set with cost below maximum");

   // An accepted edge always goes to the table read cycle.
   a_edge_reads: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.mode == MODE_EDGE) |=> state_ff == S_READ)
      else $error("edge word did not start a table read");

   // The missing flag drops only through a clear word or reset.
   a_missing_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(missing_seen_ff) |->
         ($past(reset) || $past(req_accept && req_data.mode == MODE_CLEAR)))
      else $error("missing flag dropped without a clear");

   // Division always finishes in the multiply state.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_cnt_ff == DCNT_LAST) |=> state_ff == S_MUL)
      else $error("divider did not hand off to multiply");

endmodule
